// ===== sv/ghp_pkg.sv =====
// Shared types, constants and helpers of the gray histogram block.
`timescale 1ns / 1ps

package ghp_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int OUT_W       = 24;
    localparam int PIX_W       = 8;
    localparam int CMD_W       = 2;
    localparam int NUM_BINS    = 1 << PIX_W;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    localparam t_cnt CNT_MAX = '1;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_COUNT,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [PIX_W-1:0] addr;
    } t_op;

    function automatic t_cnt sat_inc(t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

endpackage

// ===== sv/ghp_if.sv =====
// Stream interfaces for the command channel and the result channel.
`timescale 1ns / 1ps

interface ghp_in_if;
    logic                        valid;
    logic                        ready;
    logic [ghp_pkg::CMD_W-1:0]   cmd;
    logic [ghp_pkg::PIX_W-1:0]   pixel_value;
    logic [ghp_pkg::PIX_W-1:0]   bin_index;

    modport source (output valid, cmd, pixel_value, bin_index, input ready);
    modport sink   (input valid, cmd, pixel_value, bin_index, output ready);
endinterface

interface ghp_out_if;
    logic                        valid;
    logic                        ready;
    logic [ghp_pkg::OUT_W-1:0]   bin_count;
    logic [ghp_pkg::OUT_W-1:0]   peak_count;
    logic [ghp_pkg::OUT_W-1:0]   pixel_total;

    modport source (output valid, bin_count, peak_count, pixel_total, input ready);
    modport sink   (input valid, bin_count, peak_count, pixel_total, output ready);
endinterface

// ===== sv/ghp_front.sv =====
// Front end: takes command beats, decodes them into operations, queues them.
`timescale 1ns / 1ps

module ghp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ghp_in_if.sink        i_in,
    output logic          o_q_valid,
    output ghp_pkg::t_op  o_q_data,
    input  logic          i_q_pop
);

    ghp_pkg::t_op                 r_q [ghp_pkg::Q_DEPTH];
    logic [ghp_pkg::Q_AW-1:0]     r_wp;
    logic [ghp_pkg::Q_AW-1:0]     r_rp;
    logic [ghp_pkg::Q_AW:0]       r_cnt;
    logic                         w_push;
    logic                         w_pop;
    ghp_pkg::t_op                 w_op;

    // Unused command code 3 behaves as a read.
    always_comb begin
        unique case (i_in.cmd)
            ghp_pkg::CMD_CLEAR: begin
                w_op.kind = ghp_pkg::K_CLEAR;
                w_op.addr = i_in.bin_index;
            end
            ghp_pkg::CMD_COUNT: begin
                w_op.kind = ghp_pkg::K_COUNT;
                w_op.addr = i_in.pixel_value;
            end
            default: begin
                w_op.kind = ghp_pkg::K_READ;
                w_op.addr = i_in.bin_index;
            end
        endcase
    end

    assign i_in.ready = (r_cnt != (ghp_pkg::Q_AW + 1)'(ghp_pkg::Q_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_data   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/ghp_back.sv =====
// Back end: bin memory, read-modify-write sequencer, peak/total and result register.
`timescale 1ns / 1ps

module ghp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ghp_pkg::t_op  i_q_data,
    output logic          o_q_pop,
    ghp_out_if.source     o_res
);

    typedef enum logic {
        S_IDLE,
        S_RMW
    } t_state;

    t_state                             r_state;
    ghp_pkg::t_cnt                      r_mem [ghp_pkg::NUM_BINS];
    logic [ghp_pkg::NUM_BINS-1:0]       r_bin_vld;
    ghp_pkg::t_cnt                      r_rd_data;
    logic                               r_rd_vld;
    ghp_pkg::t_kind                     r_kind;
    logic [ghp_pkg::PIX_W-1:0]          r_addr;
    ghp_pkg::t_cnt                      r_peak;
    ghp_pkg::t_cnt                      r_total;
    logic                               r_out_valid;
    ghp_pkg::t_cnt                      r_out_bin;
    ghp_pkg::t_cnt                      r_out_peak;
    ghp_pkg::t_cnt                      r_out_total;

    logic                               w_pop;
    logic                               w_wr;
    ghp_pkg::t_cnt                      w_cur;
    ghp_pkg::t_cnt                      n_bin;
    ghp_pkg::t_cnt                      n_peak;
    ghp_pkg::t_cnt                      n_total;

    // Result register must be free (or draining) before a new op starts.
    assign w_pop   = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || o_res.ready);
    assign o_q_pop = w_pop;
    assign w_wr    = (r_state == S_RMW) && (r_kind == ghp_pkg::K_COUNT);

    // A bin not written since the last clear reads as zero.
    assign w_cur   = r_rd_vld ? r_rd_data : '0;
    assign n_bin   = ghp_pkg::sat_inc(w_cur);
    assign n_peak  = (n_bin > r_peak) ? n_bin : r_peak;
    assign n_total = ghp_pkg::sat_inc(r_total);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_addr] <= n_bin;
        end
        if (w_pop) begin
            r_rd_data <= r_mem[i_q_data.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_vld   <= '0;
            r_peak      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A clear pop reloads the result register itself.
            if (r_out_valid && o_res.ready &&
                !(w_pop && (i_q_data.kind == ghp_pkg::K_CLEAR))) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_kind <= i_q_data.kind;
                        r_addr <= i_q_data.addr;
                        if (i_q_data.kind == ghp_pkg::K_CLEAR) begin
                            r_bin_vld   <= '0;
                            r_peak      <= '0;
                            r_total     <= '0;
                            r_out_bin   <= '0;
                            r_out_peak  <= '0;
                            r_out_total <= '0;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_rd_vld <= r_bin_vld[i_q_data.addr];
                            r_state  <= S_RMW;
                        end
                    end
                end
                S_RMW: begin
                    if (r_kind == ghp_pkg::K_COUNT) begin
                        r_bin_vld[r_addr] <= 1'b1;
                        r_peak      <= n_peak;
                        r_total     <= n_total;
                        r_out_bin   <= n_bin;
                        r_out_peak  <= n_peak;
                        r_out_total <= n_total;
                    end else begin
                        r_out_bin   <= w_cur;
                        r_out_peak  <= r_peak;
                        r_out_total <= r_total;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.bin_count   = ghp_pkg::OUT_W'(r_out_bin);
    assign o_res.peak_count  = ghp_pkg::OUT_W'(r_out_peak);
    assign o_res.pixel_total = ghp_pkg::OUT_W'(r_out_total);

endmodule

// ===== sv/gray_histogram_with_peak_unit.sv =====
// Top level of the 256-bin gray histogram with peak and total tracking.
// Usage:
//   i_in  carries one command per beat: clear (cmd 0), count pixel_value
//         (cmd 1) or read bin_index (cmd 2; code 3 also reads).
//   o_res returns exactly one beat per command: bin_count, peak_count and
//         pixel_total, all saturating at 2^24-1.
// Path: a clear goes through the command queue straight into the result
//   register; a count or read also passes the registered bin read and write-back.
// Throughput: the back end takes no new command while a count or read does its
//   registered read of the bin memory and then its write-back; a clear is done at its pop.
//   A two-entry command queue lets new beats land while the back end works.
// Reset: synchronous, active low. All bins, the peak and the total read as
//   zero afterwards; bin valid flags are cleared at once, so no sweep of the
//   memory is needed, and the same holds for a clear command.
// Stall: while o_res.ready is low the result is held, the back end stops
//   after its current op and the queue fills; i_in.ready drops when full.
`timescale 1ns / 1ps

module gray_histogram_with_peak_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ghp_in_if.sink     i_in,
    ghp_out_if.source  o_res
);

    logic          w_q_valid;
    ghp_pkg::t_op  w_q_data;
    logic          w_q_pop;

    ghp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data),
        .i_q_pop   (w_q_pop)
    );

    ghp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== sv/ghp_chk.sv =====
// Port-level checks of the gray histogram block, bound to the top level.
`timescale 1ns / 1ps

module ghp_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [ghp_pkg::OUT_W-1:0]  i_bin_count,
    input logic [ghp_pkg::OUT_W-1:0]  i_peak_count,
    input logic [ghp_pkg::OUT_W-1:0]  i_pixel_total
);

    // No stale result survives reset.
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_bin_count) && $stable(i_peak_count) && $stable(i_pixel_total))
        else $error("result changed while stalled");

    // Peak tracks the largest bin, so no reported bin may exceed it.
    a_peak_ge_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_peak_count >= i_bin_count)
        else $error("bin count above peak");

    // Every count into a bin also counts into the total.
    a_total_ge_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pixel_total >= i_peak_count)
        else $error("peak above pixel total");

endmodule

bind gray_histogram_with_peak_unit ghp_chk u_ghp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_bin_count   (o_res.bin_count),
    .i_peak_count  (o_res.peak_count),
    .i_pixel_total (o_res.pixel_total)
);

// ===== verif/ghp_hist_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the gray histogram: predicts every result beat from command beats and compares.

module ghp_hist_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ghp_in_if    i_cmd,
    ghp_out_if   i_res,
    output int   o_errors,
    output int   o_pending
);
    import ghp_pkg::*;

    typedef struct packed {
        t_cnt bin;
        t_cnt peak;
        t_cnt total;
    } t_hist_beat;

    // shadow copy of the histogram state
    t_cnt       shadow_bins [NUM_BINS];
    t_cnt       shadow_peak;
    t_cnt       shadow_total;
    t_hist_beat expected_beats [$];
    int         mismatch_total;
    t_hist_beat want;
    t_hist_beat got;

    function automatic t_cnt bump_sat(t_cnt v);
        if (v == CNT_MAX) return v;
        return v + t_cnt'(1);
    endfunction

    function automatic void wipe_histogram();
        for (int b = 0; b < NUM_BINS; b++) shadow_bins[b] = '0;
        shadow_peak  = '0;
        shadow_total = '0;
    endfunction

    function automatic t_hist_beat histogram_step(logic [CMD_W-1:0] cmd,
                                                  logic [PIX_W-1:0] pix,
                                                  logic [PIX_W-1:0] idx);
        t_hist_beat r;
        t_cnt       c;
        if (cmd == CMD_CLEAR) begin
            wipe_histogram();
            c = '0;
        end else if (cmd == CMD_COUNT) begin
            c = bump_sat(shadow_bins[pix]);
            shadow_bins[pix] = c;
            if (c > shadow_peak) shadow_peak = c;
            shadow_total = bump_sat(shadow_total);
        end else begin
            // read, and the spare code behaves as a read
            c = shadow_bins[idx];
        end
        r.bin   = c;
        r.peak  = shadow_peak;
        r.total = shadow_total;
        return r;
    endfunction

    function automatic int field_differs(string name, t_cnt exp_v, t_cnt act_v);
        if (exp_v === act_v) return 0;
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        return 1;
    endfunction

    initial begin
        mismatch_total = 0;
        o_errors       = 0;
        o_pending      = 0;
        wipe_histogram();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_histogram();
            expected_beats.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.bin_count, i_res.peak_count, i_res.pixel_total};
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: bin %0d peak %0d total %0d",
                           got.bin, got.peak, got.total);
                    mismatch_total++;
                end else begin
                    want = expected_beats.pop_front();
                    mismatch_total += field_differs("bin_count", want.bin, got.bin);
                    mismatch_total += field_differs("peak_count", want.peak, got.peak);
                    mismatch_total += field_differs("pixel_total", want.total, got.total);
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_beats.push_back(
                    histogram_step(i_cmd.cmd, i_cmd.pixel_value, i_cmd.bin_index));
        end
        o_errors  <= mismatch_total;
        o_pending <= expected_beats.size();
    end

endmodule

// ===== verif/gray_histogram_with_peak_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: directed and frame-based random histogram commands under random backpressure.

module gray_histogram_with_peak_unit_tb;
    import ghp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int HOLD_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 750;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   rx_beats;
    bit   rx_hold;
    int   tx_quiet;
    int   rx_quiet;

    ghp_in_if  cmd_ch ();
    ghp_out_if res_ch ();

    gray_histogram_with_peak_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_res   (res_ch)
    );

    ghp_hist_checker i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    // idle cycles before the next beat, with occasional runs of back-to-back beats
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    endfunction

    // valid stays high after acceptance; a drain lowers it, the next call only if it draws a gap
    task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] pix,
                             input logic [PIX_W-1:0] idx);
        int gap;
        gap = rx_hold ? 0 : draw_gap(tx_quiet);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= cmd;
        cmd_ch.pixel_value <= pix;
        cmd_ch.bin_index   <= idx;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // result side: random stalls plus two long holds that back up the block
    initial begin : result_sink
        int stall;
        rx_beats     = 0;
        rx_hold      = 1'b0;
        rx_quiet     = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_beats == 150 || rx_beats == 450) begin
                stall   = HOLD_CYCLES;
                rx_hold = 1'b1;
            end else begin
                stall = draw_gap(rx_quiet);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_hold = 1'b0;
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            rx_beats++;
        end
    end

    initial begin : stimulus
        int               sent;
        int               frame_len;
        int               mode;
        int               roll;
        bit               paused;
        logic [PIX_W-1:0] hot;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] recent;

        tx_quiet           = 0;
        sent               = 0;
        paused             = 1'b0;
        recent             = '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.cmd         <= CMD_CLEAR;
        cmd_ch.pixel_value <= '0;
        cmd_ch.bin_index   <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, field extremes, unused fields, spare code, repeats
        issue_cmd(CMD_CLEAR, 8'hFF, 8'hFF);
        issue_cmd(CMD_READ, 8'hFF, 8'h00);
        issue_cmd(CMD_READ, 8'h00, 8'hFF);
        issue_cmd(CMD_COUNT, 8'h00, 8'hFF);
        issue_cmd(CMD_COUNT, 8'hFF, 8'h00);
        issue_cmd(CMD_COUNT, 8'hFF, 8'hAA);
        issue_cmd(CMD_COUNT, 8'hFF, 8'h55);
        issue_cmd(CMD_COUNT, 8'h00, 8'h00);
        issue_cmd(CMD_COUNT, 8'h55, 8'hFF);
        issue_cmd(CMD_COUNT, 8'hAA, 8'h00);
        issue_cmd(CMD_READ, 8'h00, 8'hFF);
        issue_cmd(CMD_SPARE, 8'h00, 8'hFF);
        issue_cmd(CMD_SPARE, 8'hFF, 8'h00);
        // same bin several times in a row exercises back-to-back read-modify-writes of one bin
        repeat (4) issue_cmd(CMD_COUNT, 8'h80, 8'h7F);
        issue_cmd(CMD_READ, 8'h7F, 8'h80);
        issue_cmd(CMD_CLEAR, 8'h00, 8'h00);
        issue_cmd(CMD_READ, 8'h00, 8'hFF);
        issue_cmd(CMD_COUNT, 8'h01, 8'hFE);
        issue_cmd(CMD_READ, 8'hFE, 8'h01);
        issue_cmd(CMD_COUNT, 8'hFE, 8'h01);
        issue_cmd(CMD_READ, 8'h01, 8'hFE);
        drain_results();

        // random frames: clear, then mostly pixel counts with reads and some noise
        while (sent < RANDOM_ITEMS) begin
            issue_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom));
            sent++;
            frame_len = $urandom_range(10, 80);
            mode      = $urandom_range(0, 2);
            hot       = 8'($urandom);
            repeat (frame_len) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0: pix = 8'($urandom);
                    1: pix = hot + 8'($urandom_range(0, 3));
                    default: pix = ($urandom_range(0, 1) == 0) ? hot : 8'($urandom);
                endcase
                if (roll < 70) begin
                    issue_cmd(CMD_COUNT, pix, 8'($urandom));
                    recent = pix;
                end else if (roll < 88) begin
                    issue_cmd(CMD_READ, 8'($urandom),
                              ($urandom_range(0, 1) == 0) ? recent : 8'($urandom));
                end else if (roll < 94) begin
                    issue_cmd(CMD_SPARE, 8'($urandom),
                              ($urandom_range(0, 1) == 0) ? recent : 8'($urandom));
                end else if (roll < 97) begin
                    issue_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom));
                end else begin
                    issue_cmd(CMD_COUNT, 8'($urandom), 8'($urandom));
                end
                sent++;
                if (!paused && sent >= RANDOM_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("gray_histogram_with_peak_unit_tb: PASS");
        end else begin
            $display("gray_histogram_with_peak_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("gray_histogram_with_peak_unit_tb: FAIL");
        $finish;
    end

endmodule
